// ===== rtl/miae_pkg.sv =====
// shared types and constants for the mono icon align and expand block
package miae_pkg;

  localparam int ROW_BITS  = 32;
  localparam int ROW_NUM_W = 5;
  localparam int COORD_W   = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ROW_BITS-1:0]       row_pix_t;
  typedef logic [ROW_NUM_W-1:0]      row_num_t;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT   = 3'd0,
    REG_RECT_TOP    = 3'd1,
    REG_RECT_RIGHT  = 3'd2,
    REG_RECT_BOTTOM = 3'd3,
    REG_ALIGN_MODE  = 3'd4
  } reg_idx_t;

  // per-axis alignment code
  typedef enum logic [1:0] {
    AX_NONE   = 2'd0,
    AX_CENTER = 2'd1,
    AX_NEAR   = 2'd2,
    AX_FAR    = 2'd3
  } axis_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SETTLE = 2'd1,
    ST_SCAN   = 2'd2
  } scan_state_t;

  // origin pipeline is three registers deep, so settle counts 2 down to 0
  localparam logic [1:0] SETTLE_START = 2'd2;

endpackage

// ===== rtl/miae_if.sv =====
// channel interfaces for rows in, pixel coordinates out and configuration writes
interface miae_in_if;
  logic                 valid;
  logic                 ready;
  miae_pkg::row_num_t   row_number;
  miae_pkg::row_pix_t   row_pixels;
  modport source (output valid, row_number, row_pixels, input ready);
  modport sink   (input valid, row_number, row_pixels, output ready);
endinterface

interface miae_out_if;
  logic                 valid;
  logic                 ready;
  miae_pkg::coord_t     pixel_x;
  miae_pkg::coord_t     pixel_y;
  logic                 last_of_row;
  modport source (output valid, pixel_x, pixel_y, last_of_row, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_row, output ready);
endinterface

interface miae_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [miae_pkg::CFG_IDX_W-1:0]      index;
  logic [miae_pkg::COORD_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mono_icon_align_and_expand_core.sv =====
// Mono icon align and expand: takes one row of a one-bit icon with its row
// number and, for each set pixel left to right, delivers the destination x/y
// inside the configured rectangle, flagging the last pixel of the row. A row
// with set pixels is taken, waits in the settle state while the alignment
// origin settles, then the pixel shift register scans it one column per
// cycle up to and including its last set pixel (at most 32 columns), holding
// a set pixel while the output is held by backpressure. Rows that are empty
// or past the icon height are taken and produce nothing. Configuration
// writes are always ready and take effect for the next row.
module mono_icon_align_and_expand_core #(
  parameter int ICON_WIDTH  = 32,
  parameter int ICON_HEIGHT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  miae_in_if.sink     in_ch,
  miae_out_if.source  out_ch,
  miae_cfg_if.sink    cfg_ch
);
  import miae_pkg::*;

  coord_t     rect_left_r, rect_left_nxt;
  coord_t     rect_top_r, rect_top_nxt;
  coord_t     rect_right_r, rect_right_nxt;
  coord_t     rect_bottom_r, rect_bottom_nxt;
  logic [3:0] align_mode_r, align_mode_nxt;
  coord_t     org_x;
  coord_t     org_y;

  always_comb begin
    rect_left_nxt   = rect_left_r;
    rect_top_nxt    = rect_top_r;
    rect_right_nxt  = rect_right_r;
    rect_bottom_nxt = rect_bottom_r;
    align_mode_nxt  = align_mode_r;
    if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_RECT_LEFT:   rect_left_nxt   = cfg_ch.data;
        REG_RECT_TOP:    rect_top_nxt    = cfg_ch.data;
        REG_RECT_RIGHT:  rect_right_nxt  = cfg_ch.data;
        REG_RECT_BOTTOM: rect_bottom_nxt = cfg_ch.data;
        REG_ALIGN_MODE:  align_mode_nxt  = cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r   <= '0;
      rect_top_r    <= '0;
      rect_right_r  <= '0;
      rect_bottom_r <= '0;
      align_mode_r  <= '0;
    end else begin
      rect_left_r   <= rect_left_nxt;
      rect_top_r    <= rect_top_nxt;
      rect_right_r  <= rect_right_nxt;
      rect_bottom_r <= rect_bottom_nxt;
      align_mode_r  <= align_mode_nxt;
    end
  end

  assign cfg_ch.ready = 1'b1;

  // horizontal mode sits in bits 3:2, vertical in bits 1:0
  miae_align #(.SIZE(ICON_WIDTH)) u_align_x (
    .clk    (clk),
    .lo     (rect_left_r),
    .hi     (rect_right_r),
    .mode   (align_mode_r[3:2]),
    .origin (org_x)
  );

  miae_align #(.SIZE(ICON_HEIGHT)) u_align_y (
    .clk    (clk),
    .lo     (rect_top_r),
    .hi     (rect_bottom_r),
    .mode   (align_mode_r[1:0]),
    .origin (org_y)
  );

  miae_scan #(.ICON_WIDTH(ICON_WIDTH), .ICON_HEIGHT(ICON_HEIGHT)) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .org_x  (org_x),
    .org_y  (org_y)
  );

endmodule

// ===== rtl/miae_align.sv =====
// three-stage origin pipeline for one axis of the target rectangle
module miae_align #(
  parameter int SIZE = 32
) (
  input  logic             clk,
  input  miae_pkg::coord_t lo,
  input  miae_pkg::coord_t hi,
  input  logic [1:0]       mode,
  output miae_pkg::coord_t origin
);
  import miae_pkg::*;

  localparam coord_t SIZE_C = coord_t'(SIZE);

  coord_t              span_r, span_nxt;
  coord_t              half_r, half_nxt;
  logic                gt_r, gt_nxt;
  coord_t              origin_r, origin_nxt;
  logic signed [16:0]  diff;
  logic signed [16:0]  rnd;

  always_comb begin
    span_nxt = hi - lo;
    diff     = {span_r[COORD_W-1], span_r} - 17'(SIZE);
    // round toward zero before halving
    rnd      = diff + {16'b0, diff[16]};
    half_nxt = rnd[16:1];
    gt_nxt   = span_r > SIZE_C;
  end

  always_comb begin
    case (axis_mode_t'(mode))
      AX_CENTER: origin_nxt = lo + half_r;
      AX_NEAR:   origin_nxt = lo;
      AX_FAR:    origin_nxt = hi - SIZE_C;
      default:   origin_nxt = gt_r ? lo + half_r : lo;
    endcase
  end

  always_ff @(posedge clk) begin
    span_r   <= span_nxt;
    half_r   <= half_nxt;
    gt_r     <= gt_nxt;
    origin_r <= origin_nxt;
  end

  assign origin = origin_r;

endmodule

// ===== rtl/miae_scan.sv =====
// bit-serial row scanner: shifts one column per cycle, unless a set pixel waits on a held output, and emits set pixels
module miae_scan #(
  parameter int ICON_WIDTH  = 32,
  parameter int ICON_HEIGHT = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  miae_in_if.sink          in_ch,
  miae_out_if.source       out_ch,
  input  miae_pkg::coord_t org_x,
  input  miae_pkg::coord_t org_y
);
  import miae_pkg::*;

  localparam int       COLS     = (ICON_WIDTH < ROW_BITS) ? ICON_WIDTH : ROW_BITS;
  localparam row_pix_t COL_MASK = ~({ROW_BITS{1'b1}} >> COLS);

  scan_state_t state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  row_pix_t    sh_r, sh_nxt;
  row_num_t    row_r, row_nxt;
  coord_t      x_r, x_nxt;
  coord_t      y_r, y_nxt;
  logic        out_valid_r, out_valid_nxt;
  coord_t      out_x_r, out_x_nxt;
  coord_t      out_y_r, out_y_nxt;
  logic        out_last_r, out_last_nxt;

  row_pix_t    pix_masked;
  logic        in_acc;
  logic        row_ok;
  logic        start;
  logic        bit_now;
  logic        rest_zero;
  logic        out_free;
  logic        emit;
  logic        step;

  always_comb begin
    pix_masked = in_ch.row_pixels & COL_MASK;
    in_acc     = in_ch.valid && in_ch.ready;
    row_ok     = {{(32-ROW_NUM_W){1'b0}}, in_ch.row_number} < 32'(ICON_HEIGHT);
    start      = in_acc && row_ok && (pix_masked != '0);
    bit_now    = sh_r[ROW_BITS-1];
    rest_zero  = (sh_r[ROW_BITS-2:0] == '0);
    out_free   = !out_valid_r || out_ch.ready;
    emit       = (state_r == ST_SCAN) && bit_now && out_free;
    step       = (state_r == ST_SCAN) && (!bit_now || out_free);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_SETTLE;
      ST_SETTLE: if (cnt_r == '0) state_nxt = ST_SCAN;
      ST_SCAN:   if (step && rest_zero) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt       = cnt_r;
    sh_nxt        = sh_r;
    row_nxt       = row_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sh_nxt  = pix_masked;
          row_nxt = in_ch.row_number;
          cnt_nxt = SETTLE_START;
        end
      end
      ST_SETTLE: begin
        cnt_nxt = cnt_r - 2'd1;
        if (cnt_r == '0) begin
          x_nxt = org_x;
          y_nxt = org_y + coord_t'({{(COORD_W-ROW_NUM_W){1'b0}}, row_r});
        end
      end
      ST_SCAN: begin
        if (step) begin
          sh_nxt = sh_r << 1;
          x_nxt  = x_r + coord_t'(1);
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = x_r;
      out_y_nxt     = y_r;
      out_last_nxt  = rest_zero;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    sh_r       <= sh_nxt;
    row_r      <= row_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.last_of_row = out_last_r;

`ifndef NO_ASSERTIONS
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (sh_r != '0))
    else $error("scanning an empty shift register");
  a_start_settles: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_SETTLE && cnt_r == SETTLE_START))
    else $error("row start did not enter settle");
  a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && rest_zero) |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("last pixel did not close the row");
  a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !rest_zero) |=> (x_r == $past(x_r) + coord_t'(1)))
    else $error("column counter did not advance");
`endif

endmodule
